/* hdl/irpfd_pkg.sv */
// package for the ir pulse frame decoder
// word types, register indexes, status codes, reset values and the duration check
// no dependencies
package irpfd_pkg;

    localparam int CODE_BITS_DEFAULT = 32;
    localparam int TIME_W            = 15;
    localparam int CODE_W            = 32;
    localparam int STATUS_W          = 3;
    localparam int CFG_INDEX_W       = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARK     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_HEADER_BAD = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BIT_BAD    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_END_BAD    = 3'd4;

    // register reset values
    localparam logic [TIME_W-1:0] HEADER_MARK_RESET  = 15'd4500;
    localparam logic [TIME_W-1:0] HEADER_SPACE_RESET = 15'd4500;
    localparam logic [TIME_W-1:0] BIT_MARK_RESET     = 15'd560;
    localparam logic [TIME_W-1:0] ONE_SPACE_RESET    = 15'd1690;
    localparam logic [TIME_W-1:0] ZERO_SPACE_RESET   = 15'd560;
    localparam logic [TIME_W-1:0] END_MARK_RESET     = 15'd560;
    localparam logic [TIME_W-1:0] TOLERANCE_RESET    = 15'd60;
    localparam logic              ACTIVE_LEVEL_RESET = 1'b0;

    typedef struct packed {
        logic              mark_level;
        logic [TIME_W-1:0] mark_time;
        logic              space_level;
        logic [TIME_W-1:0] space_time;
        logic              frame_end;
    } in_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    // duration strictly inside (target - tol, target + tol)
    function automatic logic near_target(
        input logic [TIME_W-1:0] d,
        input logic [TIME_W-1:0] target,
        input logic [TIME_W-1:0] tol
    );
        logic signed [TIME_W+1:0] v;
        logic signed [TIME_W+1:0] lo;
        logic signed [TIME_W+1:0] hi;
        v  = signed'({2'b00, d});
        lo = signed'({2'b00, target}) - signed'({2'b00, tol});
        hi = signed'({2'b00, target}) + signed'({2'b00, tol});
        return (v > lo) && (v < hi);
    endfunction

endpackage

/* hdl/ir_pulse_frame_decoder_core.sv */
// ir pulse frame decoder: checks header, data and end symbols, emits code and status
// uses irpfd_pkg for word types, register indexes, status codes and the duration check
// a frame-end word is held in the input register and its result word is then written to the
// result register; this can be held back while the result register still holds an untaken result
// throughput: one symbol word per cycle; input register, one compare/shift stage, result
// register; the input side stalls only when a frame-end word meets a full result register
// reset: asynchronous, active low; registers return to defaults, frame state and valids clear
module ir_pulse_frame_decoder_core #(
    parameter int CODE_BITS = irpfd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [irpfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [irpfd_pkg::TIME_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  irpfd_pkg::in_word_t                 in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output irpfd_pkg::out_word_t                out_word
);

    localparam int POS_W = $clog2(CODE_BITS + 3);
    localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(CODE_BITS + 2);
    localparam logic [POS_W-1:0] LAST_BIT  = POS_W'(CODE_BITS);

    localparam int TW = irpfd_pkg::TIME_W;

    // configuration registers
    logic [TW-1:0] header_mark_reg;
    logic [TW-1:0] header_space_reg;
    logic [TW-1:0] bit_mark_reg;
    logic [TW-1:0] one_space_reg;
    logic [TW-1:0] zero_space_reg;
    logic [TW-1:0] end_mark_reg;
    logic [TW-1:0] tolerance_reg;
    logic          active_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mark_reg  <= irpfd_pkg::HEADER_MARK_RESET;
            header_space_reg <= irpfd_pkg::HEADER_SPACE_RESET;
            bit_mark_reg     <= irpfd_pkg::BIT_MARK_RESET;
            one_space_reg    <= irpfd_pkg::ONE_SPACE_RESET;
            zero_space_reg   <= irpfd_pkg::ZERO_SPACE_RESET;
            end_mark_reg     <= irpfd_pkg::END_MARK_RESET;
            tolerance_reg    <= irpfd_pkg::TOLERANCE_RESET;
            active_level_reg <= irpfd_pkg::ACTIVE_LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                irpfd_pkg::REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                irpfd_pkg::REG_HEADER_SPACE: header_space_reg <= cfg_data;
                irpfd_pkg::REG_BIT_MARK:     bit_mark_reg     <= cfg_data;
                irpfd_pkg::REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                irpfd_pkg::REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                irpfd_pkg::REG_END_MARK:     end_mark_reg     <= cfg_data;
                irpfd_pkg::REG_TOLERANCE:    tolerance_reg    <= cfg_data;
                irpfd_pkg::REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register and pipeline control
    logic                 in_valid_reg;
    irpfd_pkg::in_word_t  in_word_reg;
    logic                 out_valid_reg;
    irpfd_pkg::out_word_t out_word_reg;
    logic                 stall;
    logic                 advance;

    assign stall    = in_valid_reg && in_word_reg.frame_end && out_valid_reg && !out_ready;
    assign advance  = in_valid_reg && !stall;
    assign in_ready = !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
    end

    // symbol checks
    logic levels_ok;
    logic tol_header_ok;
    logic bit_one_ok;
    logic bit_zero_ok;
    logic end_ok;

    assign levels_ok = (in_word_reg.mark_level == active_level_reg) &&
                       (in_word_reg.space_level != active_level_reg);

    assign tol_header_ok = levels_ok &&
        irpfd_pkg::near_target(in_word_reg.mark_time, header_mark_reg, tolerance_reg) &&
        irpfd_pkg::near_target(in_word_reg.space_time, header_space_reg, tolerance_reg);

    assign bit_one_ok = levels_ok &&
        irpfd_pkg::near_target(in_word_reg.mark_time, bit_mark_reg, tolerance_reg) &&
        irpfd_pkg::near_target(in_word_reg.space_time, one_space_reg, tolerance_reg);

    assign bit_zero_ok = levels_ok &&
        irpfd_pkg::near_target(in_word_reg.mark_time, bit_mark_reg, tolerance_reg) &&
        irpfd_pkg::near_target(in_word_reg.space_time, zero_space_reg, tolerance_reg);

    // end symbol space target is zero
    assign end_ok = levels_ok &&
        irpfd_pkg::near_target(in_word_reg.mark_time, end_mark_reg, tolerance_reg) &&
        irpfd_pkg::near_target(in_word_reg.space_time, '0, tolerance_reg);

    // frame state
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               pos_next;
    logic [CODE_BITS-1:0]           code_shift_reg;
    logic [CODE_BITS-1:0]           code_shift_next;
    logic [irpfd_pkg::STATUS_W-1:0] first_error_reg;
    logic [irpfd_pkg::STATUS_W-1:0] first_error_next;
    logic [irpfd_pkg::STATUS_W-1:0] sym_error;
    logic [irpfd_pkg::STATUS_W-1:0] status;
    logic [POS_W-1:0]               pos_step;
    logic [CODE_BITS-1:0]           code_step;
    logic [irpfd_pkg::STATUS_W-1:0] error_step;

    always_comb
    begin
        pos_step   = pos_reg;
        code_step  = code_shift_reg;
        error_step = first_error_reg;
        sym_error  = irpfd_pkg::STATUS_OK;
        if (pos_reg < FRAME_LEN)
        begin
            if (pos_reg == '0)
            begin
                sym_error = tol_header_ok ? irpfd_pkg::STATUS_OK : irpfd_pkg::STATUS_HEADER_BAD;
            end
            else if (pos_reg <= LAST_BIT)
            begin
                code_step = {code_shift_reg[CODE_BITS-2:0], bit_one_ok};
                sym_error = (bit_one_ok || bit_zero_ok) ? irpfd_pkg::STATUS_OK
                                                        : irpfd_pkg::STATUS_BIT_BAD;
            end
            else
            begin
                sym_error = end_ok ? irpfd_pkg::STATUS_OK : irpfd_pkg::STATUS_END_BAD;
            end
            if (first_error_reg == irpfd_pkg::STATUS_OK)
            begin
                error_step = sym_error;
            end
            pos_step = pos_reg + POS_W'(1);
        end

        // short frame overrides any symbol error
        status = (pos_step < FRAME_LEN) ? irpfd_pkg::STATUS_SHORT : error_step;

        if (in_word_reg.frame_end)
        begin
            pos_next         = '0;
            code_shift_next  = '0;
            first_error_next = irpfd_pkg::STATUS_OK;
        end
        else
        begin
            pos_next         = pos_step;
            code_shift_next  = code_step;
            first_error_next = error_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            code_shift_reg  <= '0;
            first_error_reg <= irpfd_pkg::STATUS_OK;
        end
        else if (advance)
        begin
            pos_reg         <= pos_next;
            code_shift_reg  <= code_shift_next;
            first_error_reg <= first_error_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_word_reg.frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_word_reg.frame_end)
        begin
            out_word_reg.status <= status;
            out_word_reg.code   <= (status == irpfd_pkg::STATUS_OK)
                                   ? irpfd_pkg::CODE_W'(code_step) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
